>>> rtl/core/slipdf_pkg.sv
package slipdf_pkg;

    localparam int FRAME_MAX = 1514;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 12;
    localparam int STATE_W = 2;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;

    localparam logic [BYTE_W-1:0] SL_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] SL_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] SL_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] SL_ESC_ESC = 8'hDD;

    localparam logic [MODE_W-1:0] MODE_SLIP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PASS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DROP = 2'd2;

    localparam logic [STATE_W-1:0] PS_OUTSIDE = 2'd0;
    localparam logic [STATE_W-1:0] PS_FRAME   = 2'd1;
    localparam logic [STATE_W-1:0] PS_ESCAPE  = 2'd2;

    localparam logic [KIND_W-1:0] K_CONSOLE  = 3'd0;
    localparam logic [KIND_W-1:0] K_DATA     = 3'd1;
    localparam logic [KIND_W-1:0] K_END      = 3'd2;
    localparam logic [KIND_W-1:0] K_ESCABORT = 3'd3;
    localparam logic [KIND_W-1:0] K_OVERFLOW = 3'd4;

    localparam logic [ADDR_W-1:0] ADDR_MODE = 2'd0;

    localparam logic [POS_W-1:0] FRAME_MAX_C = POS_W'(FRAME_MAX);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  position;
    } result_t;

endpackage

>>> rtl/core/slip_deframer_with_passthrough_top.sv
// an accepted byte is registered at the input, then its result in the output register
// throughput: one byte per cycle unless stalled; one parser state update per byte
// bytes that yield no result (END opening a frame, ESC, discard mode) are absorbed
// a waiting result stalls the input once the input register holds a byte with a result
// reset: aresetn synchronous active low, clears mode, parser state, count and valids
module slip_deframer_with_passthrough_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slipdf_pkg::ADDR_W-1:0]     paddr,
    input  logic [slipdf_pkg::DATA_W-1:0]     pwdata,
    output logic [slipdf_pkg::DATA_W-1:0]     prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [slipdf_pkg::BYTE_W-1:0]     s_in_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [slipdf_pkg::KIND_W-1:0]     m_out_kind,
    output logic [slipdf_pkg::BYTE_W-1:0]     m_out_byte,
    output logic [slipdf_pkg::POS_W-1:0]      m_position
);
    import slipdf_pkg::*;

    logic [MODE_W-1:0] mode;
    result_t           result;

    slipdf_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    slipdf_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    assign m_out_kind = result.kind;
    assign m_out_byte = result.data;
    assign m_position = result.position;

endmodule

>>> rtl/core/slipdf_apb_regs.sv
module slipdf_apb_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slipdf_pkg::ADDR_W-1:0]     paddr,
    input  logic [slipdf_pkg::DATA_W-1:0]     pwdata,
    output logic [slipdf_pkg::DATA_W-1:0]     prdata,
    output logic                              pready,
    output logic [slipdf_pkg::MODE_W-1:0]     mode
);
    import slipdf_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_MODE);

    always_comb begin
        mode_next = mode_reg;
        if (wr_en) begin
            mode_next = pwdata[MODE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SLIP;
        end else begin
            mode_reg <= mode_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_MODE) begin
            prdata = {{(DATA_W-MODE_W){1'b0}}, mode_reg};
        end
    end

    assign mode = mode_reg;

endmodule

>>> rtl/core/slipdf_step.sv
module slipdf_step (
    input  logic [slipdf_pkg::MODE_W-1:0]  mode,
    input  logic [slipdf_pkg::STATE_W-1:0] state_cur,
    input  logic [slipdf_pkg::POS_W-1:0]   count_cur,
    input  logic [slipdf_pkg::BYTE_W-1:0]  in_byte,
    output logic                           has_result,
    output slipdf_pkg::result_t            result,
    output logic [slipdf_pkg::STATE_W-1:0] state_nxt,
    output logic [slipdf_pkg::POS_W-1:0]   count_nxt
);
    import slipdf_pkg::*;

    logic              is_data;
    logic [BYTE_W-1:0] data_val;
    logic              full;

    assign full = (count_cur >= FRAME_MAX_C);

    always_comb begin
        has_result = 1'b0;
        result     = '0;
        state_nxt  = state_cur;
        count_nxt  = count_cur;
        is_data    = 1'b0;
        data_val   = in_byte;
        case (mode)
            MODE_SLIP: begin
                case (state_cur)
                    PS_FRAME: begin
                        if (in_byte == SL_ESC) begin
                            state_nxt = PS_ESCAPE;
                        end else if (in_byte == SL_END) begin
                            state_nxt       = PS_OUTSIDE;
                            has_result      = 1'b1;
                            result.kind     = K_END;
                            result.position = count_cur;
                        end else begin
                            is_data = 1'b1;
                        end
                    end
                    PS_ESCAPE: begin
                        if (in_byte == SL_ESC_END) begin
                            is_data  = 1'b1;
                            data_val = SL_END;
                        end else if (in_byte == SL_ESC_ESC) begin
                            is_data  = 1'b1;
                            data_val = SL_ESC;
                        end else begin
                            state_nxt       = PS_OUTSIDE;
                            has_result      = 1'b1;
                            result.kind     = K_ESCABORT;
                            result.position = count_cur;
                        end
                    end
                    default: begin
                        if (in_byte == SL_END) begin
                            state_nxt = PS_FRAME;
                            count_nxt = '0;
                        end else begin
                            state_nxt   = PS_OUTSIDE;
                            has_result  = 1'b1;
                            result.kind = K_CONSOLE;
                            result.data = in_byte;
                        end
                    end
                endcase
                if (is_data) begin
                    has_result      = 1'b1;
                    result.position = count_cur;
                    if (full) begin
                        state_nxt   = PS_OUTSIDE;
                        result.kind = K_OVERFLOW;
                    end else begin
                        state_nxt   = PS_FRAME;
                        count_nxt   = count_cur + 1'b1;
                        result.kind = K_DATA;
                        result.data = data_val;
                    end
                end
            end
            MODE_PASS: begin
                has_result  = 1'b1;
                result.kind = K_CONSOLE;
                result.data = in_byte;
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/slipdf_pipe.sv
module slipdf_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [slipdf_pkg::MODE_W-1:0] mode,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [slipdf_pkg::BYTE_W-1:0] s_in_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output slipdf_pkg::result_t           m_result
);
    import slipdf_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic [POS_W-1:0]   count_reg;
    logic [POS_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;
    result_t            step_result;
    logic               step_has;
    logic               out_free;
    logic               advance;

    slipdf_step u_step (
        .mode       (mode),
        .state_cur  (state_reg),
        .count_cur  (count_reg),
        .in_byte    (in_byte_reg),
        .has_result (step_has),
        .result     (step_result),
        .state_nxt  (state_next),
        .count_nxt  (count_next)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!step_has || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = advance && step_has;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PS_OUTSIDE;
            count_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
        if (advance && step_has) begin
            out_reg <= step_result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FRAME_MAX_C)
        else $error("frame count beyond limit");

    a_console_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.kind == K_CONSOLE) |-> out_reg.position == '0)
        else $error("console transaction with nonzero position");

    a_ctrl_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.kind == K_END || out_reg.kind == K_ESCABORT
                          || out_reg.kind == K_OVERFLOW) |-> out_reg.data == '0)
        else $error("control transaction carries a byte");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

endmodule
